// ===== src/tpdw_pkg.sv =====
// ---------------------------------------------------------------------------
// tpdw_pkg: shared types and constants of the tyre pressure-drop warning
// Opcodes, sensor mode codes, speed limit and the item/update structs used
// between the evaluation logic and the per-wheel state.
// ---------------------------------------------------------------------------
package tpdw_pkg;

  localparam logic [1:0] OP_EVAL      = 2'd0;
  localparam logic [1:0] OP_CLEAR_ONE = 2'd1;
  localparam logic [1:0] OP_CLEAR_ALL = 2'd2;

  localparam logic [1:0]  MODE_MASK      = 2'h3;
  localparam logic [1:0]  MODE_DELTA     = 2'h2;
  localparam logic [15:0] MIN_SPEED      = 16'd20;
  localparam logic [7:0]  THRESHOLD_INIT = 8'd16;

  // One registered input item
  typedef struct packed {
    logic [1:0]  opcode;
    logic [1:0]  wheel;
    logic [7:0]  pressure;
    logic [1:0]  sensor_mode;
    logic [15:0] vehicle_speed;
  } item_t;

  // State update requested by one item
  typedef struct packed {
    logic       wr_ref;
    logic [7:0] ref_val;
    logic       wr_flag;
    logic       flag_val;
    logic       clr_one;
    logic       clr_all;
  } upd_t;

endpackage

// ===== src/tpdw_eval.sv =====
// ---------------------------------------------------------------------------
// tpdw_eval: decision logic for one item
// Compares the sample against the selected wheel's reference and warning bit
// and produces the result bit together with the state update.
// ---------------------------------------------------------------------------
module tpdw_eval (
  input  tpdw_pkg::item_t item,
  input  logic            wheel_hit,
  input  logic [7:0]      ref_sel,
  input  logic            flag_sel,
  input  logic [7:0]      threshold,
  output logic            result,
  output tpdw_pkg::upd_t  upd
);

  logic [8:0] drop_sum;
  logic       speed_zero;
  logic       drop_seen;

  // Compare without wrap: the sum carries a ninth bit
  assign drop_sum   = {1'b0, item.pressure} + {1'b0, threshold};
  assign speed_zero = (item.vehicle_speed == '0);
  assign drop_seen  = ((item.sensor_mode & tpdw_pkg::MODE_MASK) == tpdw_pkg::MODE_DELTA) &&
                      (item.vehicle_speed >= tpdw_pkg::MIN_SPEED) &&
                      (drop_sum <= {1'b0, ref_sel});

  // Decide result and state update
  always_comb begin
    result       = 1'b0;
    upd          = '0;
    upd.ref_val  = item.pressure;
    case (item.opcode)
      tpdw_pkg::OP_EVAL: begin
        if (wheel_hit) begin
          if (ref_sel == '0) begin
            // learn the wheel
            upd.wr_ref   = 1'b1;
            upd.wr_flag  = 1'b1;
            upd.flag_val = 1'b0;
          end else if (drop_seen) begin
            upd.wr_flag  = 1'b1;
            upd.flag_val = 1'b1;
            result       = 1'b1;
          end else if (flag_sel) begin
            // hold the warning until the vehicle stands
            if (speed_zero) begin
              upd.wr_flag  = 1'b1;
              upd.flag_val = 1'b0;
            end else begin
              result = 1'b1;
            end
          end else begin
            // relearn at standstill
            upd.wr_ref = speed_zero;
          end
        end
      end
      tpdw_pkg::OP_CLEAR_ONE: begin
        upd.clr_one = wheel_hit;
        upd.clr_all = !wheel_hit;
      end
      tpdw_pkg::OP_CLEAR_ALL: begin
        upd.clr_all = 1'b1;
      end
      default: begin
        result = 1'b0;
      end
    endcase
  end

endmodule

// ===== src/tpdw_state.sv =====
// ---------------------------------------------------------------------------
// tpdw_state: per-wheel reference pressures and warning bits
// Selects the addressed wheel's entries and applies the update of an item.
// ---------------------------------------------------------------------------
module tpdw_state #(
  parameter int WHEELS = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [1:0]     wheel,
  input  logic           upd_en,
  input  tpdw_pkg::upd_t upd,
  output logic           wheel_hit,
  output logic [7:0]     ref_sel,
  output logic           flag_sel
);

  logic [7:0]        ref_pressure [WHEELS];
  logic [WHEELS-1:0] warn_flag;
  logic [WHEELS-1:0] sel;

  // Decode the wheel index
  always_comb begin
    for (int i = 0; i < WHEELS; i++) begin
      sel[i] = (int'(wheel) == i);
    end
  end

  // Read the selected wheel
  always_comb begin
    ref_sel  = '0;
    flag_sel = 1'b0;
    for (int i = 0; i < WHEELS; i++) begin
      if (sel[i]) begin
        ref_sel  = ref_pressure[i];
        flag_sel = warn_flag[i];
      end
    end
  end

  assign wheel_hit = |sel;

  // Update references and warning bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WHEELS; i++) begin
        ref_pressure[i] <= '0;
      end
      warn_flag <= '0;
    end else if (upd_en) begin
      for (int i = 0; i < WHEELS; i++) begin
        if (upd.clr_all || (upd.clr_one && sel[i])) begin
          ref_pressure[i] <= '0;
        end else if (upd.wr_ref && sel[i]) begin
          ref_pressure[i] <= upd.ref_val;
        end
        if (upd.wr_flag && sel[i]) begin
          warn_flag[i] <= upd.flag_val;
        end
      end
    end
  end

endmodule

// ===== src/tire_pressure_drop_warning.sv =====
// ---------------------------------------------------------------------------
// tire_pressure_drop_warning: per-wheel hard pressure-drop warning
// Keeps a learned reference pressure and a warning bit for each wheel and
// answers every item with one warning bit.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries opcode, wheel, pressure,
//   sensor_mode and vehicle_speed. Opcode evaluate checks a sample, clear one
//   and clear all forget learned references (warning bits are kept).
//   Output channel (out_valid / out_stall) returns the warning bit, one item
//   for every input item, in order; reset items always return 0.
//   Configuration channel (cfg_valid / cfg_ready) writes drop_threshold; it
//   is always ready; the user must write it only while the block is idle;
//   the block itself does not enforce this. The item waits in the input
//   register; when the result register is free, the compare and update
//   load the result register and out_valid rises. Throughput is one item
//   per cycle while the receiver does not stall; the per-wheel registers
//   are read and written in that single cycle, so the next item sees the
//   new state. When the receiver stalls, the result register holds its
//   item and the input register can still take one more before in_stall
//   rises. Reset (rst, synchronous) empties both registers, sets the
//   threshold to 16 and marks every wheel unlearned with its warning clear.
// ---------------------------------------------------------------------------
module tire_pressure_drop_warning #(
  parameter int WHEELS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [1:0]  wheel,
  input  logic [7:0]  pressure,
  input  logic [1:0]  sensor_mode,
  input  logic [15:0] vehicle_speed,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        warning,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  drop_threshold
);

  tpdw_pkg::item_t item_q;
  logic            item_valid;
  logic            advance;
  logic [7:0]      threshold;
  logic            wheel_hit;
  logic [7:0]      ref_sel;
  logic            flag_sel;
  logic            result;
  tpdw_pkg::upd_t  upd;

  // Move the held item on when the result register is free
  assign advance   = item_valid && (!out_valid || !out_stall);
  assign in_stall  = item_valid && !advance;
  assign cfg_ready = 1'b1;

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= tpdw_pkg::THRESHOLD_INIT;
    end else if (cfg_valid && cfg_ready) begin
      threshold <= drop_threshold;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_q.opcode        <= opcode;
      item_q.wheel         <= wheel;
      item_q.pressure      <= pressure;
      item_q.sensor_mode   <= sensor_mode;
      item_q.vehicle_speed <= vehicle_speed;
    end
  end

  tpdw_state #(
    .WHEELS(WHEELS)
  ) u_state (
    .clk      (clk),
    .rst      (rst),
    .wheel    (item_q.wheel),
    .upd_en   (advance),
    .upd      (upd),
    .wheel_hit(wheel_hit),
    .ref_sel  (ref_sel),
    .flag_sel (flag_sel)
  );

  tpdw_eval u_eval (
    .item     (item_q),
    .wheel_hit(wheel_hit),
    .ref_sel  (ref_sel),
    .flag_sel (flag_sel),
    .threshold(threshold),
    .result   (result),
    .upd      (upd)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      warning <= result;
    end
  end

  // Checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !item_valid |-> !in_stall)
    else $error("input stalled with an empty input register");

  a_reset_item_no_warning: assert property (@(posedge clk) disable iff (rst)
    (advance && item_q.opcode != tpdw_pkg::OP_EVAL) |=> (out_valid && !warning))
    else $error("reset item returned a warning");

  a_standstill_no_warning: assert property (@(posedge clk) disable iff (rst)
    (advance && item_q.vehicle_speed == '0) |=> (out_valid && !warning))
    else $error("warning reported at standstill");

endmodule
